// ===== rtl/core/nbsf_pkg.sv =====
// Shared widths, limits and the stored-body layout for the softened force block.
// No dependencies; compile first.
package nbsf_pkg;

   localparam int POS_W    = 32;
   localparam int MASS_W   = 32;
   localparam int IDX_W    = 10;
   localparam int FORCE_W  = 48;
   localparam int COUNT_W  = 11;
   localparam int SOFT_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BODY_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SOFTENING  = 2'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd0;
   localparam logic [SOFT_W-1:0]  SOFT_RESET  = 32'd655;

   // clip limits of a term magnitude and of the sums, Q24.24
   localparam logic [FORCE_W-1:0] TERM_LIM = 48'h8000_0000_0000;
   localparam logic signed [FORCE_W+1:0] SUM_MAX = 50'sh0_7FFF_FFFF_FFFF;
   localparam logic signed [FORCE_W+1:0] SUM_MIN = -50'sh0_8000_0000_0000;

   typedef struct packed {
      logic [MASS_W-1:0]        mass;
      logic signed [POS_W-1:0]  pz;
      logic signed [POS_W-1:0]  py;
      logic signed [POS_W-1:0]  px;
   } body_type;

endpackage

// ===== rtl/core/nbsf_channels.sv =====
// Handshake channel interfaces: request, response and register write.
// Depends on nbsf_pkg.
interface nbsf_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 mode;
   logic [nbsf_pkg::IDX_W-1:0]           body_index;
   logic signed [nbsf_pkg::POS_W-1:0]    pos_x;
   logic signed [nbsf_pkg::POS_W-1:0]    pos_y;
   logic signed [nbsf_pkg::POS_W-1:0]    pos_z;
   logic [nbsf_pkg::MASS_W-1:0]          body_mass;
   modport source (output valid, mode, body_index, pos_x, pos_y, pos_z, body_mass,
                   input ready);
   modport sink (input valid, mode, body_index, pos_x, pos_y, pos_z, body_mass,
                 output ready);
endinterface

interface nbsf_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [nbsf_pkg::IDX_W-1:0]           result_index;
   logic signed [nbsf_pkg::FORCE_W-1:0]  force_x;
   logic signed [nbsf_pkg::FORCE_W-1:0]  force_y;
   logic signed [nbsf_pkg::FORCE_W-1:0]  force_z;
   logic                                 saturated;
   modport source (output valid, result_index, force_x, force_y, force_z, saturated,
                   input ready);
   modport sink (input valid, result_index, force_x, force_y, force_z, saturated,
                 output ready);
endinterface

interface nbsf_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [nbsf_pkg::CSR_IDX_W-1:0]       index;
   logic [nbsf_pkg::CSR_DAT_W-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/nbody_softened_force.sv =====
// Softened all-pairs gravity: body store, sequencer and one shared multiplier.
// Depends on nbsf_pkg and the channel interfaces in nbsf_channels.sv.
//
// Use: req_chan carries items. mode 0 loads one body into the store at
// body_index and finishes in the cycle it is taken. mode 1 evaluates the force
// on body body_index over the first body_count stored bodies and returns one
// item on rsp_chan. csr_chan writes body_count (index 0) or softening
// (index 1); it is always ready and must only be used while idle.
// Per evaluation the shared multiplier squares the softening once; for each
// stored body j it squares the three coordinate differences and adds them to
// that square for r^2, then runs a 42-step square root, forms partial products
// for r^3 and, per axis, runs a 112-step restoring divide (an axis with zero
// numerator skips the divide). req_chan is not ready while an evaluation
// runs, so one item is in work at a time.
// A finished result sits in the output register; a load or the next evaluate
// is taken meanwhile, and an evaluate that finishes while rsp_chan still
// stalls waits until the previous item is taken.
// Reset clears the control state, the registers to their defaults and the
// output valid; the store is undefined until loaded.
module nbody_softened_force #(
   parameter int MAX_BODIES = 1024
) (
   input logic       clock,
   input logic       reset,
   nbsf_req_if.sink  req_chan,
   nbsf_rsp_if.source rsp_chan,
   nbsf_csr_if.sink  csr_chan
);

   localparam int AW  = $clog2(MAX_BODIES);
   localparam int CW  = $clog2(MAX_BODIES + 1);
   localparam int DW  = (CW > nbsf_pkg::COUNT_W) ? CW : nbsf_pkg::COUNT_W;
   localparam int R2W = 67;
   localparam int SQW = 42;
   localparam int SVW = 2 * SQW;
   localparam int SRW = SQW + 3;
   localparam int R3W = 109;
   localparam int NW  = 112;
   localparam int MW  = 34;
   localparam int PW  = 2 * MW;
   localparam int FW  = nbsf_pkg::FORCE_W;
   localparam int QSTICKY = FW;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LDI  = 4'd1;
   localparam logic [3:0] ST_EPS  = 4'd2;
   localparam logic [3:0] ST_LDJ  = 4'd3;
   localparam logic [3:0] ST_SQX  = 4'd4;
   localparam logic [3:0] ST_SQY  = 4'd5;
   localparam logic [3:0] ST_SQZ  = 4'd6;
   localparam logic [3:0] ST_SQE  = 4'd7;
   localparam logic [3:0] ST_SQRT = 4'd8;
   localparam logic [3:0] ST_R3   = 4'd9;
   localparam logic [3:0] ST_MD   = 4'd10;
   localparam logic [3:0] ST_DSET = 4'd11;
   localparam logic [3:0] ST_DIV  = 4'd12;
   localparam logic [3:0] ST_ACC  = 4'd13;
   localparam logic [3:0] ST_NEXT = 4'd14;
   localparam logic [3:0] ST_DONE = 4'd15;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Z = 2'd2;

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      mag33 = v[32] ? 33'(-v) : 33'(v);
   endfunction

   // body store
   nbsf_pkg::body_type mem [MAX_BODIES];
   nbsf_pkg::body_type rd_data_ff;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;

   // control
   logic [3:0]  state_ff, state_in;
   logic [nbsf_pkg::COUNT_W-1:0] count_ff;
   logic [nbsf_pkg::SOFT_W-1:0]  soft_ff;
   logic [CW-1:0] n_ff, j_ff;
   logic [CW-1:0] j_next;
   logic [nbsf_pkg::IDX_W-1:0] idx_ff;
   logic [1:0]  ax_ff;
   logic [2:0]  k_ff;
   logic [5:0]  sq_cnt_ff;
   logic [6:0]  div_cnt_ff;

   // datapath
   logic signed [nbsf_pkg::POS_W-1:0] pi_x_ff, pi_y_ff, pi_z_ff;
   logic signed [32:0] d_ff [3];
   logic [nbsf_pkg::MASS_W-1:0] mass_ff;
   logic [PW-1:0]  prod_ff;
   logic [MW-1:0]  mul_a, mul_b;
   logic [64:0]    eps2_ff;
   logic [R2W-1:0] r2_ff, r2_in;
   logic [SVW-1:0] sq_v_ff;
   logic [SRW-1:0] sq_rem_ff;
   logic [SQW-1:0] root_ff;
   logic [R3W-1:0] r3_ff, r3_in;
   logic [NW-1:0]  num_ff;
   logic [R3W-1:0] rem_ff;
   logic [FW-1:0]  q_ff;
   logic           sticky_ff;
   logic signed [FW-1:0] acc_ff [3];
   logic           clip_ff;

   // output register
   logic           out_valid_ff;
   logic [nbsf_pkg::IDX_W-1:0] out_idx_ff;
   logic signed [FW-1:0] out_fx_ff, out_fy_ff, out_fz_ff;
   logic           out_sat_ff;

   logic req_acc, rsp_acc, csr_acc;
   logic [DW-1:0] idx_ext, count_ext, n_calc;
   logic idx_ok;

   assign req_acc = req_chan.valid && req_chan.ready;
   assign rsp_acc = out_valid_ff && rsp_chan.ready;
   assign csr_acc = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.result_index = out_idx_ff;
   assign rsp_chan.force_x      = out_fx_ff;
   assign rsp_chan.force_y      = out_fy_ff;
   assign rsp_chan.force_z      = out_fz_ff;
   assign rsp_chan.saturated    = out_sat_ff;

   assign idx_ext   = DW'(req_chan.body_index);
   assign idx_ok    = idx_ext < DW'(MAX_BODIES);
   assign count_ext = DW'(count_ff);
   assign n_calc    = (count_ext > DW'(MAX_BODIES)) ? DW'(MAX_BODIES) : count_ext;
   assign j_next    = j_ff + CW'(1);

   // store write and registered read
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = j_ff[AW-1:0];
      case (state_ff)
         ST_IDLE: begin
            rd_en   = req_acc && req_chan.mode;
            rd_addr = idx_ext[AW-1:0];
         end
         ST_LDI:  rd_en = 1'b1;
         ST_NEXT: begin
            rd_en   = j_next < n_ff;
            rd_addr = j_next[AW-1:0];
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_acc && !req_chan.mode && idx_ok) begin
         mem[idx_ext[AW-1:0]] <= '{mass: req_chan.body_mass, pz: req_chan.pos_z,
                                   py: req_chan.pos_y, px: req_chan.pos_x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LDI: begin
            mul_a = MW'(soft_ff);
            mul_b = MW'(soft_ff);
         end
         ST_SQX: begin
            mul_a = MW'(mag33(d_ff[0]));
            mul_b = MW'(mag33(d_ff[0]));
         end
         ST_SQY: begin
            mul_a = MW'(mag33(d_ff[1]));
            mul_b = MW'(mag33(d_ff[1]));
         end
         ST_SQZ: begin
            mul_a = MW'(mag33(d_ff[2]));
            mul_b = MW'(mag33(d_ff[2]));
         end
         ST_R3: begin
            case (k_ff)
               3'd0: begin
                  mul_a = r2_ff[MW-1:0];
                  mul_b = root_ff[MW-1:0];
               end
               3'd1: begin
                  mul_a = r2_ff[MW-1:0];
                  mul_b = MW'(root_ff[SQW-1:MW]);
               end
               3'd2: begin
                  mul_a = MW'(r2_ff[R2W-1:MW]);
                  mul_b = root_ff[MW-1:0];
               end
               3'd3: begin
                  mul_a = MW'(r2_ff[R2W-1:MW]);
                  mul_b = MW'(root_ff[SQW-1:MW]);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_MD: begin
            mul_a = MW'(mass_ff);
            mul_b = MW'(mag33(d_ff[ax_ff]));
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // combinational pieces of the shared add/compare paths
   logic [SRW-1:0] sq_rem_sh, sq_trial;
   logic           sq_ge;
   logic [R3W:0]   div_sh;
   logic           div_ge;
   logic           qbit;
   logic [FW-1:0]  term_mag;
   logic           term_clip;
   logic signed [FW:0]   term;
   logic signed [FW+1:0] sum;

   assign sq_rem_sh = {sq_rem_ff[SRW-3:0], sq_v_ff[SVW-1 -: 2]};
   assign sq_trial  = SRW'({root_ff, 2'b01});
   assign sq_ge     = sq_rem_sh >= sq_trial;

   assign div_sh = {rem_ff, num_ff[NW-1]};
   assign div_ge = div_sh >= {1'b0, r3_ff};
   assign qbit   = div_ge;

   assign term_clip = sticky_ff || (q_ff > nbsf_pkg::TERM_LIM);
   assign term_mag  = term_clip ? nbsf_pkg::TERM_LIM : q_ff;
   assign term      = d_ff[ax_ff][32] ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
   assign sum       = (FW+2)'(acc_ff[ax_ff]) + (FW+2)'(term);

   always_comb begin
      r2_in = r2_ff;
      case (state_ff)
         ST_SQY:  r2_in = R2W'(eps2_ff) + R2W'(prod_ff[64:0]);
         ST_SQZ,
         ST_SQE:  r2_in = r2_ff + R2W'(prod_ff[64:0]);
         default: r2_in = r2_ff;
      endcase
   end

   always_comb begin
      r3_in = r3_ff;
      case (k_ff)
         3'd1:    r3_in = r3_ff + R3W'(prod_ff);
         3'd2,
         3'd3:    r3_in = r3_ff + R3W'({prod_ff, 34'b0});
         3'd4:    r3_in = r3_ff + R3W'({prod_ff, 68'b0});
         default: r3_in = r3_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_chan.mode) begin
               state_in = (idx_ok && (n_calc != '0)) ? ST_LDI : ST_DONE;
            end
         end
         ST_LDI:  state_in = ST_EPS;
         ST_EPS:  state_in = ST_LDJ;
         ST_LDJ:  state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SQZ;
         ST_SQZ:  state_in = ST_SQE;
         ST_SQE:  state_in = ST_SQRT;
         ST_SQRT: state_in = (sq_cnt_ff == 6'(SQW - 1)) ? ST_R3 : ST_SQRT;
         ST_R3: begin
            if (k_ff == 3'd4) begin
               state_in = (r3_in == '0) ? ST_NEXT : ST_MD;
            end
         end
         ST_MD:   state_in = ST_DSET;
         ST_DSET: state_in = (prod_ff[63:0] == '0) ? ST_ACC : ST_DIV;
         ST_DIV:  state_in = (div_cnt_ff == '0) ? ST_ACC : ST_DIV;
         ST_ACC:  state_in = (ax_ff == AX_Z) ? ST_NEXT : ST_MD;
         ST_NEXT: state_in = (j_next < n_ff) ? ST_LDJ : ST_DONE;
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= nbsf_pkg::COUNT_RESET;
         soft_ff      <= nbsf_pkg::SOFT_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_acc) begin
            case (csr_chan.index)
               nbsf_pkg::CSR_BODY_COUNT: count_ff <= csr_chan.data[nbsf_pkg::COUNT_W-1:0];
               nbsf_pkg::CSR_SOFTENING:  soft_ff  <= csr_chan.data[nbsf_pkg::SOFT_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == ST_DONE && (!out_valid_ff || rsp_chan.ready)) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_acc) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_chan.mode) begin
               idx_ff    <= req_chan.body_index;
               n_ff      <= n_calc[CW-1:0];
               j_ff      <= '0;
               clip_ff   <= 1'b0;
               acc_ff[0] <= '0;
               acc_ff[1] <= '0;
               acc_ff[2] <= '0;
            end
         end
         ST_LDI: begin
            pi_x_ff <= rd_data_ff.px;
            pi_y_ff <= rd_data_ff.py;
            pi_z_ff <= rd_data_ff.pz;
         end
         ST_EPS:  eps2_ff <= prod_ff[64:0];
         ST_LDJ: begin
            d_ff[0] <= 33'(rd_data_ff.px) - 33'(pi_x_ff);
            d_ff[1] <= 33'(rd_data_ff.py) - 33'(pi_y_ff);
            d_ff[2] <= 33'(rd_data_ff.pz) - 33'(pi_z_ff);
            mass_ff <= rd_data_ff.mass;
         end
         ST_SQY, ST_SQZ: r2_ff <= r2_in;
         ST_SQE: begin
            r2_ff     <= r2_in;
            sq_v_ff   <= {1'b0, r2_in, 16'b0};
            sq_rem_ff <= '0;
            root_ff   <= '0;
            sq_cnt_ff <= '0;
         end
         ST_SQRT: begin
            sq_v_ff   <= {sq_v_ff[SVW-3:0], 2'b00};
            sq_rem_ff <= sq_ge ? (sq_rem_sh - sq_trial) : sq_rem_sh;
            root_ff   <= {root_ff[SQW-2:0], sq_ge};
            sq_cnt_ff <= sq_cnt_ff + 6'd1;
            k_ff      <= '0;
            r3_ff     <= '0;
         end
         ST_R3: begin
            r3_ff <= r3_in;
            k_ff  <= k_ff + 3'd1;
            ax_ff <= AX_X;
         end
         ST_DSET: begin
            num_ff     <= {prod_ff[63:0], 48'b0};
            rem_ff     <= '0;
            q_ff       <= '0;
            sticky_ff  <= 1'b0;
            div_cnt_ff <= 7'(NW - 1);
         end
         ST_DIV: begin
            num_ff     <= {num_ff[NW-2:0], 1'b0};
            rem_ff     <= div_ge ? R3W'(div_sh - {1'b0, r3_ff}) : div_sh[R3W-1:0];
            q_ff       <= {q_ff[FW-2:0], qbit};
            sticky_ff  <= sticky_ff || (qbit && (div_cnt_ff >= 7'(QSTICKY)));
            div_cnt_ff <= div_cnt_ff - 7'd1;
         end
         ST_ACC: begin
            // clip the sum into Q24.24 range
            if (sum > nbsf_pkg::SUM_MAX) begin
               acc_ff[ax_ff] <= FW'(nbsf_pkg::SUM_MAX);
               clip_ff       <= 1'b1;
            end else if (sum < nbsf_pkg::SUM_MIN) begin
               acc_ff[ax_ff] <= FW'(nbsf_pkg::SUM_MIN);
               clip_ff       <= 1'b1;
            end else begin
               acc_ff[ax_ff] <= FW'(sum);
               clip_ff       <= clip_ff || term_clip;
            end
            ax_ff <= ax_ff + 2'd1;
         end
         ST_NEXT: j_ff <= j_next;
         ST_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_idx_ff <= idx_ff;
               out_fx_ff  <= acc_ff[0];
               out_fy_ff  <= acc_ff[1];
               out_fz_ff  <= acc_ff[2];
               out_sat_ff <= clip_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

// ===== rtl/core/nbsf_checker.sv =====
// Port-level checks for nbody_softened_force, attached by the bind below.
// Depends on nbsf_pkg and the top level's channel ports.
module nbsf_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_mode,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [nbsf_pkg::FORCE_W-1:0] rsp_force_x,
   input logic [nbsf_pkg::IDX_W-1:0]          rsp_index
);

   // no result item straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x) && $stable(rsp_index))
      else $error("stalled result changed");

   // an evaluate item blocks the request side next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode |=> !req_ready)
      else $error("ready after evaluate item");

   // a load item never raises a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_mode && !rsp_valid |=> !rsp_valid)
      else $error("result after load item");

endmodule

bind nbody_softened_force nbsf_checker u_nbsf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .req_mode    (req_chan.mode),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_force_x (rsp_chan.force_x),
   .rsp_index   (rsp_chan.result_index)
);
